### hw/rtl/fas_pkg.sv
package fas_pkg;

	// Map geometry
	localparam int MAP_BYTES_DEF = 1024;
	localparam int WORD_BYTES    = 8;
	localparam int WB_W          = 3;
	localparam int MEM_REG_W     = 11;

	// Configuration register indexes
	localparam logic REG_FIT_MODE  = 1'b0;
	localparam logic REG_MEM_BYTES = 1'b1;
	localparam logic [MEM_REG_W-1:0] MEM_BYTES_RST = 11'd1024;

	typedef enum logic [1:0] {
		CMD_FIND  = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [10:0] request_size;
		logic [9:0]  range_base;
		logic [10:0] range_end;
	} in_item_t;

	typedef struct packed {
		logic       success;
		logic [9:0] run_address;
	} out_item_t;

	// Sequencer to datapath controls
	typedef struct packed {
		logic clear;
		logic load;
		logic word_valid;
		logic reply;
	} ctl_t;

endpackage

### hw/rtl/fas_ram.sv
module fas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/fas_ctrl.sv
module fas_ctrl #(
	parameter int NW = 128,
	parameter int IW = $clog2(NW)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output fas_pkg::ctl_t ctl,
	output logic [IW-1:0] rd_addr,
	output logic [IW-1:0] widx_s1
);

	localparam logic [IW-1:0] LAST = IW'(NW - 1);

	fas_pkg::state_t state_q, state_d;
	logic [IW-1:0]   rd_q;
	logic            valid_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fas_pkg::ST_CLEAR: if (rd_q == LAST) state_d = fas_pkg::ST_IDLE;
			fas_pkg::ST_IDLE:  if (start) state_d = fas_pkg::ST_SCAN;
			fas_pkg::ST_SCAN:  if (rd_q == LAST) state_d = fas_pkg::ST_DRAIN;
			fas_pkg::ST_DRAIN: state_d = fas_pkg::ST_REPLY;
			fas_pkg::ST_REPLY: state_d = fas_pkg::ST_IDLE;
			default:           state_d = fas_pkg::ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		ctl.clear      = (state_q == fas_pkg::ST_CLEAR);
		ctl.load       = (state_q == fas_pkg::ST_IDLE) && start;
		ctl.word_valid = valid_s1;
		ctl.reply      = (state_q == fas_pkg::ST_REPLY);
		busy           = (state_q != fas_pkg::ST_IDLE);
		rd_addr        = rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fas_pkg::ST_CLEAR;
			rd_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == fas_pkg::ST_SCAN);
			if (state_q == fas_pkg::ST_CLEAR || state_q == fas_pkg::ST_SCAN) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
		end
	end

	// word index of the read data arriving next cycle
	always_ff @(posedge clk) begin
		widx_s1 <= rd_q;
	end

endmodule

### hw/rtl/fas_scan.sv
module fas_scan #(
	parameter int MAP_BYTES = 1024,
	parameter int IW        = $clog2(MAP_BYTES / fas_pkg::WORD_BYTES)
) (
	input  logic                              clk,
	input  fas_pkg::ctl_t                     ctl,
	input  fas_pkg::in_item_t                 item,
	input  logic                              fit_mode,
	input  logic [fas_pkg::MEM_REG_W-1:0]     mem_bytes,
	input  logic [IW-1:0]                     widx_s1,
	input  logic [fas_pkg::WORD_BYTES-1:0]    rdata,
	output logic                              we,
	output logic [fas_pkg::WORD_BYTES-1:0]    wdata,
	output fas_pkg::out_item_t                result
);

	localparam int AW = $clog2(MAP_BYTES);
	localparam int CW = $clog2(MAP_BYTES + 1);
	localparam int LW = (CW > fas_pkg::MEM_REG_W) ? CW : fas_pkg::MEM_REG_W;

	logic [1:0]    cmd_q;
	logic [LW-1:0] size_q, base_q, end_q, m_q, m_d;
	logic          fit_q, mark_ok_q;
	logic [LW-1:0] len_q, blen_q, cnt_q;
	logic [AW-1:0] start_q, baddr_q;
	logic          found_q;

	logic [LW-1:0] len_v, blen_v, cnt_v, pos;
	logic [AW-1:0] start_v, baddr_v;
	logic          found_v, free_b;
	logic [fas_pkg::WORD_BYTES-1:0] mask;
	logic          pend, fnd_f;
	logic [AW-1:0] addr_f;
	logic          ok;

	// managed size clipped to the map
	assign m_d = (LW'(mem_bytes) > LW'(MAP_BYTES)) ? LW'(MAP_BYTES) : LW'(mem_bytes);

	// Walk the eight bytes of one word
	always_comb begin
		len_v   = len_q;
		start_v = start_q;
		found_v = found_q;
		blen_v  = blen_q;
		baddr_v = baddr_q;
		cnt_v   = cnt_q;
		mask    = '0;
		for (int b = 0; b < fas_pkg::WORD_BYTES; b++) begin
			pos    = LW'({widx_s1, fas_pkg::WB_W'(b)});
			free_b = (pos < m_q) && !rdata[b];
			mask[b] = mark_ok_q && (cmd_q == fas_pkg::CMD_MARK) &&
				(pos >= base_q) && (pos < end_q);
			if (free_b) begin
				if (len_v == '0) start_v = AW'(pos);
				len_v = len_v + 1'b1;
				cnt_v = cnt_v + 1'b1;
				if (!fit_q && !found_v && len_v >= size_q) begin
					found_v = 1'b1;
					baddr_v = start_v;
				end
			end else begin
				// run closes: best fit keeps smallest, later wins ties
				if (fit_q && len_v != '0 && len_v >= size_q &&
					(!found_v || len_v <= blen_v)) begin
					found_v = 1'b1;
					blen_v  = len_v;
					baddr_v = start_v;
				end
				len_v = '0;
			end
		end
	end

	assign we    = ctl.word_valid && (mask != '0);
	assign wdata = rdata | mask;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q     <= item.command;
			size_q    <= LW'(item.request_size);
			base_q    <= LW'(item.range_base);
			end_q     <= LW'(item.range_end);
			m_q       <= m_d;
			fit_q     <= fit_mode;
			mark_ok_q <= LW'(item.range_end) < m_d;
			len_q     <= '0;
			start_q   <= '0;
			found_q   <= 1'b0;
			blen_q    <= '0;
			baddr_q   <= '0;
			cnt_q     <= '0;
		end else if (ctl.word_valid) begin
			len_q   <= len_v;
			start_q <= start_v;
			found_q <= found_v;
			blen_q  <= blen_v;
			baddr_q <= baddr_v;
			cnt_q   <= cnt_v;
		end
	end

	// Close a run still open at the end of the map and form the result for each command
	always_comb begin
		pend   = fit_q && len_q != '0 && len_q >= size_q && (!found_q || len_q <= blen_q);
		fnd_f  = found_q || pend;
		addr_f = pend ? start_q : baddr_q;
		case (cmd_q)
			fas_pkg::CMD_FIND:  ok = (size_q <= m_q) && fnd_f;
			fas_pkg::CMD_MARK:  ok = mark_ok_q;
			fas_pkg::CMD_CHECK: ok = (size_q <= m_q) && (cnt_q >= size_q);
			default:            ok = 1'b0;
		endcase
		result.success     = ok;
		result.run_address = (ok && cmd_q == fas_pkg::CMD_FIND) ? 10'(addr_f) : '0;
	end

endmodule

### hw/rtl/free_run_allocator_search_top.sv
// An accepted start walks the states SCAN, DRAIN and REPLY; done is registered from REPLY.
// NW = MAP_BYTES / 8. One item at a time: a new start is taken only once the block is idle.
// The cost is the sweep of the occupancy RAM, one 8-byte word read per cycle.
// Reset clears config and control, then clears the map word by word with busy high.
// Each result shows for one cycle on done; the receiver cannot stall.
module free_run_allocator_search_top #(
	parameter int MAP_BYTES = fas_pkg::MAP_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  fas_pkg::in_item_t             item,
	output logic                          done,
	output fas_pkg::out_item_t            result,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [fas_pkg::MEM_REG_W-1:0] cfg_data
);

	localparam int NW = MAP_BYTES / fas_pkg::WORD_BYTES;
	localparam int IW = $clog2(NW);

	logic                          fit_q;
	logic [fas_pkg::MEM_REG_W-1:0] mem_q;
	fas_pkg::ctl_t                 ctl;
	logic [IW-1:0]                 rd_addr, widx_s1;
	logic [fas_pkg::WORD_BYTES-1:0] rdata, scan_wdata;
	logic                          scan_we;
	fas_pkg::out_item_t            res_d;
	logic                          done_q;
	fas_pkg::out_item_t            result_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q <= 1'b0;
			mem_q <= fas_pkg::MEM_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fas_pkg::REG_FIT_MODE:  fit_q <= cfg_data[0];
				fas_pkg::REG_MEM_BYTES: mem_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fas_ctrl #(.NW(NW), .IW(IW)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.widx_s1 (widx_s1)
	);

	fas_ram #(.WIDTH(fas_pkg::WORD_BYTES), .DEPTH(NW)) u_map (
		.clk   (clk),
		.we    (ctl.clear | scan_we),
		.waddr (ctl.clear ? rd_addr : widx_s1),
		.wdata (ctl.clear ? '0 : scan_wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	fas_scan #(.MAP_BYTES(MAP_BYTES), .IW(IW)) u_scan (
		.clk       (clk),
		.ctl       (ctl),
		.item      (item),
		.fit_mode  (fit_q),
		.mem_bytes (mem_q),
		.widx_s1   (widx_s1),
		.rdata     (rdata),
		.we        (scan_we),
		.wdata     (scan_wdata),
		.result    (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.reply;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.reply) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hw/rtl/fas_chk.sv
module fas_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input fas_pkg::out_item_t  result
);

	// done is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held over two cycles");

	// an accepted item makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised after accept");

	// no result in the cycle right after an accept
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done) else $error("result too early");

	// failed results carry address zero
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.success) |-> (result.run_address == '0))
		else $error("nonzero address on failure");

endmodule

bind free_run_allocator_search_top fas_chk u_fas_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.result    (result)
);
